// ----- sv/sdtp_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtp_pkg
// Shared widths, character codes and microcode types of the decimal text placer.
// ----------------------------------------------------------------------------
package sdtp_pkg;

    localparam int CHAR_WIDTH_DEF = 6;

    localparam int START_W   = 7;
    localparam int ROW_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int COL_W     = 8;
    localparam int CODE_W    = 7;

    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int ND_W       = $clog2(NUM_DIGITS + 1);

    localparam logic [CODE_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CODE_W-1:0] ASCII_MINUS = 7'd45;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_CONV,
        OP_SKIP,
        OP_SIGN,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BITS_LEFT,
        COND_SKIP_MORE,
        COND_MORE_DIGITS
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic bits_left;
        logic skip_more;
        logic more_digits;
    } t_flags;

endpackage

// ----- sv/sdtp_if.sv -----
// ----------------------------------------------------------------------------
// sdtp_in_if / sdtp_out_if
// Valid/ready channels for numbers in and character cells out.
// ----------------------------------------------------------------------------
interface sdtp_in_if import sdtp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [START_W-1:0]        start_column;
    logic [ROW_W-1:0]          text_row;
    logic signed [VALUE_W-1:0] value;

    modport source(output valid, start_column, text_row, value, input ready);
    modport sink(input valid, start_column, text_row, value, output ready);
endinterface

interface sdtp_out_if import sdtp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [CODE_W-1:0]  char_code;
    logic               last;

    modport source(output valid, column, row, char_code, last, input ready);
    modport sink(input valid, column, row, char_code, last, output ready);
endinterface

// ----- sv/sdtp_seq.sv -----
// ----------------------------------------------------------------------------
// sdtp_seq
// Microcode ROM and step counter; jumps on datapath flags, holds on stall.
// ----------------------------------------------------------------------------
module sdtp_seq import sdtp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_go,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    localparam t_pc PC_LOAD = t_pc'(0);
    localparam t_pc PC_CONV = t_pc'(1);
    localparam t_pc PC_SKIP = t_pc'(2);
    localparam t_pc PC_SIGN = t_pc'(3);
    localparam t_pc PC_EMIT = t_pc'(4);
    localparam t_pc PC_DONE = t_pc'(5);

    function automatic t_ctrl rom(input t_pc pc);
        t_ctrl cw;
        unique case (pc)
            PC_LOAD: cw = '{op: OP_LOAD, cond: COND_NEVER,       target: PC_LOAD};
            PC_CONV: cw = '{op: OP_CONV, cond: COND_BITS_LEFT,   target: PC_CONV};
            PC_SKIP: cw = '{op: OP_SKIP, cond: COND_SKIP_MORE,   target: PC_SKIP};
            PC_SIGN: cw = '{op: OP_SIGN, cond: COND_NEVER,       target: PC_LOAD};
            PC_EMIT: cw = '{op: OP_EMIT, cond: COND_MORE_DIGITS, target: PC_EMIT};
            PC_DONE: cw = '{op: OP_NOP,  cond: COND_ALWAYS,      target: PC_LOAD};
            default: cw = '{op: OP_NOP,  cond: COND_ALWAYS,      target: PC_LOAD};
        endcase
        return cw;
    endfunction

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl cw;
    logic  take;

    assign cw     = rom(r_pc);
    assign o_ctrl = cw;

    always_comb begin
        unique case (cw.cond)
            COND_NEVER:       take = 1'b0;
            COND_ALWAYS:      take = 1'b1;
            COND_BITS_LEFT:   take = i_flags.bits_left;
            COND_SKIP_MORE:   take = i_flags.skip_more;
            COND_MORE_DIGITS: take = i_flags.more_digits;
            default:          take = 1'b1;
        endcase
    end

    always_comb begin
        if (!i_go) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = cw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- sv/signed_decimal_text_placer.sv -----
// ----------------------------------------------------------------------------
// signed_decimal_text_placer
// Signed 32-bit number to a run of positioned ASCII character cells.
// ----------------------------------------------------------------------------
// One number is taken at a time. An item passes through a load step, the
// one-bit-per-cycle shift-add-3 binary to BCD loop, steps that strip leading
// zeros, the sign slot, steps that emit the digits and a step to return.
// Characters leave through an output register, so a stalled sink holds the
// sequencer at the next sign or emit step only. Zero gives a single '0'; the
// most negative value prints in full as eleven characters.
module signed_decimal_text_placer import sdtp_pkg::*; #(
    parameter int CHAR_WIDTH = CHAR_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdtp_in_if.sink    i_in,
    sdtp_out_if.source o_out
);

    t_ctrl  ctrl;
    t_flags flags;
    logic   go;
    logic   slot_free;
    logic   emit;

    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [BCD_W-1:0]     adj;
    logic [BIT_CNT_W-1:0] r_bits;
    logic [ND_W-1:0]      r_nd;
    logic                 r_neg;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;

    logic                 r_out_valid;
    logic [COL_W-1:0]     r_out_col;
    logic [ROW_W-1:0]     r_out_row;
    logic [CODE_W-1:0]    r_out_code;
    logic                 r_out_last;

    logic [VALUE_W-1:0]   in_raw;
    logic [VALUE_W-1:0]   in_mag;
    logic [3:0]           top;

    sdtp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign in_raw = i_in.value;
    assign in_mag = in_raw[VALUE_W-1] ? (VALUE_W'(0) - in_raw) : in_raw;
    assign top    = r_bcd[BCD_W-1 -: 4];

    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        unique case (ctrl.op)
            OP_LOAD: go = i_in.valid;
            OP_SIGN: go = !r_neg || slot_free;
            OP_EMIT: go = slot_free;
            default: go = 1'b1;
        endcase
    end

    // a character is loaded into the output register this cycle
    assign emit = go && (((ctrl.op == OP_SIGN) && r_neg) || (ctrl.op == OP_EMIT));

    assign flags.bits_left   = (r_bits != '0);
    assign flags.more_digits = (r_nd != ND_W'(1));
    assign flags.skip_more   = (top == 4'd0) && (r_nd != ND_W'(1));

    assign i_in.ready = (ctrl.op == OP_LOAD);

    // add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bits      <= '0;
            r_nd        <= ND_W'(NUM_DIGITS);
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (ctrl.op)
                OP_LOAD: begin
                    if (go) begin
                        r_bin  <= in_mag;
                        r_bcd  <= '0;
                        r_bits <= BIT_CNT_W'(VALUE_W - 1);
                        r_nd   <= ND_W'(NUM_DIGITS);
                        r_neg  <= in_raw[VALUE_W-1];
                        r_col  <= COL_W'(i_in.start_column);
                        r_row  <= i_in.text_row;
                    end
                end
                OP_CONV: begin
                    {r_bcd, r_bin} <= {adj[BCD_W-2:0], r_bin, 1'b0};
                    r_bits         <= r_bits - BIT_CNT_W'(1);
                end
                OP_SKIP: begin
                    if (flags.skip_more) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_nd  <= r_nd - ND_W'(1);
                    end
                end
                OP_SIGN: begin
                    if (r_neg && go) begin
                        r_out_col   <= r_col;
                        r_out_row   <= r_row;
                        r_out_code  <= ASCII_MINUS;
                        r_out_last  <= 1'b0;
                        r_col       <= r_col + COL_W'(CHAR_WIDTH);
                    end
                end
                OP_EMIT: begin
                    if (go) begin
                        r_out_col   <= r_col;
                        r_out_row   <= r_row;
                        r_out_code  <= ASCII_ZERO + CODE_W'(top);
                        r_out_last  <= !flags.more_digits;
                        r_col       <= r_col + COL_W'(CHAR_WIDTH);
                        r_bcd       <= {r_bcd[BCD_W-5:0], 4'd0};
                        // count stays at one after the final digit
                        if (flags.more_digits) begin
                            r_nd <= r_nd - ND_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.column    = r_out_col;
    assign o_out.row       = r_out_row;
    assign o_out.char_code = r_out_code;
    assign o_out.last      = r_out_last;

`ifndef SYNTHESIS
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nd != '0) && (r_nd <= ND_W'(NUM_DIGITS)))
        else $error("digit count out of range");

    a_load_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_bits == BIT_CNT_W'(VALUE_W - 1)))
        else $error("bit counter not armed on load");

    a_code_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.char_code == ASCII_MINUS) ||
                         ((o_out.char_code >= ASCII_ZERO) &&
                          (o_out.char_code <= ASCII_ZERO + CODE_W'(9)))))
        else $error("character code is neither digit nor minus");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.char_code == ASCII_MINUS)) |-> !o_out.last)
        else $error("minus sign flagged as last character");

    a_no_load_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.op == OP_CONV) |-> (i_in.ready == 1'b0))
        else $error("input accepted during conversion");
`endif

endmodule
